// ----- sv/gb3_pkg.sv -----
// ---------------------------------------------------------------------------
// gb3_pkg
// Shared types and constants for the 3x3 RGB Gaussian blur unit: frame
// limits, counter widths, pixel word layout and configuration register codes.
// ---------------------------------------------------------------------------
package gb3_pkg;

    // Frame limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    // Counter widths
    localparam int COL_W    = $clog2(MAX_WIDTH);       // column index
    localparam int ROW_W    = $clog2(MAX_HEIGHT);      // output row index
    localparam int IN_ROW_W = $clog2(MAX_HEIGHT) + 1;  // input row runs to height+1 in drain

    // Configuration register fields
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

    // Reset frame size
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    // Input word kinds
    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    // Pixel word: index 0 red, 1 green, 2 blue
    localparam int CHAN_W = 8;
    typedef logic [2:0][CHAN_W-1:0] t_pixel;

endpackage

// ----- sv/gb3_ifs.sv -----
// ---------------------------------------------------------------------------
// gb3 channel interfaces
// Valid/ready channels of the blur unit: pixel input, pixel output and the
// configuration write channel.
// ---------------------------------------------------------------------------

// Pixel input channel
interface gb3_pix_in_if;
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic [gb3_pkg::CHAN_W-1:0]   red_in;
    logic [gb3_pkg::CHAN_W-1:0]   green_in;
    logic [gb3_pkg::CHAN_W-1:0]   blue_in;

    modport source (output valid, func, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, func, red_in, green_in, blue_in, output ready);
endinterface

// Pixel output channel
interface gb3_pix_out_if;
    logic                         valid;
    logic                         ready;
    logic [gb3_pkg::CHAN_W-1:0]   red_out;
    logic [gb3_pkg::CHAN_W-1:0]   green_out;
    logic [gb3_pkg::CHAN_W-1:0]   blue_out;
    logic                         frame_end;

    modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

// Configuration write channel
interface gb3_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [gb3_pkg::CFG_IDX_W-1:0]    reg_index;
    logic [gb3_pkg::CFG_DATA_W-1:0]   reg_data;

    modport source (output valid, reg_index, reg_data, input ready);
    modport sink   (input valid, reg_index, reg_data, output ready);
endinterface

// ----- sv/gaussian_blur_3x3_rgb_unit.sv -----
// ---------------------------------------------------------------------------
// gaussian_blur_3x3_rgb_unit
// 3x3 Gaussian blur (1 2 1 / 2 4 2 / 1 2 1, divided by 16) over an RGB frame
// streamed in raster order; border pixels pass through unchanged.
// ---------------------------------------------------------------------------
// Usage:
//  - i_pix takes one word per cycle while ready: func 0 carries a pixel,
//    func 1 is a drain word. The output for frame position k is completed
//    by the word for position k+width+1; after the last pixel, width+1 drain
//    words flush the rest. The first width+1 words of a frame give no output.
//  - o_pix carries the filtered pixel; frame_end marks the frame's last one.
//  - i_cfg writes frame_width (index 0) and frame_height (index 1); it is
//    always ready, and a write to either index restarts the position
//    counters. Write only while the unit is idle.
//  - Throughput: one word per cycle unless o_pix stalls. The rate is set by the
//    line store read port: each word reads both line stores once and writes
//    them back as it leaves stage 1, forwarding when the same column comes back.
//  - Path: the word that completes a result passes stage 1 and stage 2; the
//    result is valid once it reaches the output register.
//  - Reset (i_rst_n low, synchronous) clears the pipeline, window and
//    counters and selects a 640 x 480 frame. Line stores need no clearing.
//  - When o_pix is stalled the output register holds; the two pipeline
//    stages behind it keep filling, then i_pix.ready drops.
// ---------------------------------------------------------------------------
module gaussian_blur_3x3_rgb_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    gb3_pix_in_if.sink           i_pix,
    gb3_pix_out_if.source        o_pix,
    gb3_cfg_if.sink              i_cfg
);

    localparam int COL_W    = gb3_pkg::COL_W;
    localparam int ROW_W    = gb3_pkg::ROW_W;
    localparam int IN_ROW_W = gb3_pkg::IN_ROW_W;
    localparam int CHAN_W   = gb3_pkg::CHAN_W;

    // Effective last column / row index from a raw register value
    function automatic logic [COL_W-1:0] width_last(input logic [gb3_pkg::FW_W-1:0] v);
        logic [COL_W-1:0] res;
        if (v == '0) begin
            res = '0;
        end else if (v > gb3_pkg::FW_W'(gb3_pkg::MAX_WIDTH)) begin
            res = COL_W'(gb3_pkg::MAX_WIDTH - 1);
        end else begin
            res = COL_W'(v - gb3_pkg::FW_W'(1));
        end
        return res;
    endfunction

    function automatic logic [ROW_W-1:0] height_last(input logic [gb3_pkg::FH_W-1:0] v);
        logic [ROW_W-1:0] res;
        if (v == '0) begin
            res = '0;
        end else if (v > gb3_pkg::FH_W'(gb3_pkg::MAX_HEIGHT)) begin
            res = ROW_W'(gb3_pkg::MAX_HEIGHT - 1);
        end else begin
            res = ROW_W'(v - gb3_pkg::FH_W'(1));
        end
        return res;
    endfunction

    // Frame size (as last indices)
    logic [COL_W-1:0]       r_w_last;
    logic [ROW_W-1:0]       r_h_last;

    // Position counters
    logic [COL_W-1:0]       r_in_col, n_in_col;
    logic [IN_ROW_W-1:0]    r_in_row, n_in_row;
    logic [COL_W-1:0]       r_out_col, n_out_col;
    logic [ROW_W-1:0]       r_out_row, n_out_row;

    // Line stores and their read registers
    gb3_pkg::t_pixel        mem_up  [gb3_pkg::MAX_WIDTH];
    gb3_pkg::t_pixel        mem_mid [gb3_pkg::MAX_WIDTH];
    gb3_pkg::t_pixel        r_up_rd, r_mid_rd;

    // Stage 1: line store data arrives, window shifts, write-back
    logic                   r_s1v;
    logic [COL_W-1:0]       r_s1_col;
    gb3_pkg::t_pixel        r_s1_px;
    logic                   r_s1_primed, r_s1_border, r_s1_last;
    logic                   r_s1_fwd;
    gb3_pkg::t_pixel        r_fwd_up, r_fwd_mid;
    gb3_pkg::t_pixel        s1_up, s1_mid;

    // Window
    gb3_pkg::t_pixel        r_win [3][3];

    // Stage 2: filter from window
    logic                   r_s2v;
    logic                   r_s2_border, r_s2_last;
    gb3_pkg::t_pixel        blur_px;

    // Output register
    logic                   r_ov;
    gb3_pkg::t_pixel        r_o_px;
    logic                   r_o_last;

    // Handshake / flow control
    logic                   acc, cfg_wr;
    logic                   out_free, s2_free, s1_adv;
    logic                   primed, border, last;
    gb3_pkg::t_pixel        in_px;

    assign out_free = !r_ov || o_pix.ready;
    assign s2_free  = !r_s2v || out_free;
    assign s1_adv   = r_s1v && s2_free;

    assign i_pix.ready = !r_s1v || s2_free;
    assign acc         = i_pix.valid && i_pix.ready;
    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid;

    // Drain words enter as black pixels
    always_comb begin
        if (i_pix.func == gb3_pkg::FUNC_DRAIN) begin
            in_px = '0;
        end else begin
            in_px = {i_pix.blue_in, i_pix.green_in, i_pix.red_in};
        end
    end

    // Position bookkeeping for the accepted word
    always_comb begin
        primed = (r_in_row >= IN_ROW_W'(2))
              || (r_in_row == IN_ROW_W'(1) && r_in_col >= COL_W'(1));
        border = (r_out_row == '0) || (r_out_row >= r_h_last)
              || (r_out_col == '0) || (r_out_col >= r_w_last);
        last   = (r_out_row >= r_h_last) && (r_out_col >= r_w_last);

        if (r_in_col >= r_w_last) begin
            n_in_col = '0;
            n_in_row = r_in_row + IN_ROW_W'(1);
        end else begin
            n_in_col = r_in_col + COL_W'(1);
            n_in_row = r_in_row;
        end

        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (primed) begin
            if (last) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else if (r_out_col >= r_w_last) begin
                n_out_col = '0;
                n_out_row = r_out_row + ROW_W'(1);
            end else begin
                n_out_col = r_out_col + COL_W'(1);
            end
        end
    end

    // Configuration and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last  <= COL_W'(gb3_pkg::RESET_WIDTH - 1);
            r_h_last  <= ROW_W'(gb3_pkg::RESET_HEIGHT - 1);
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (cfg_wr) begin
            if (i_cfg.reg_index == gb3_pkg::CFG_FRAME_WIDTH) begin
                r_w_last  <= width_last(i_cfg.reg_data[gb3_pkg::FW_W-1:0]);
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else if (i_cfg.reg_index == gb3_pkg::CFG_FRAME_HEIGHT) begin
                r_h_last  <= height_last(i_cfg.reg_data[gb3_pkg::FH_W-1:0]);
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end
        end else if (acc) begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    // Stage 1 line store data, forwarded when the write-back hits the same column
    assign s1_up  = r_s1_fwd ? r_fwd_up  : r_up_rd;
    assign s1_mid = r_s1_fwd ? r_fwd_mid : r_mid_rd;

    // Upper line store: read on accept, write-back from stage 1
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            mem_up[r_s1_col] <= s1_mid;
        end
        if (acc) begin
            r_up_rd <= mem_up[r_in_col];
        end
    end

    // Middle line store
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            mem_mid[r_s1_col] <= r_s1_px;
        end
        if (acc) begin
            r_mid_rd <= mem_mid[r_in_col];
        end
    end

    // Stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1v <= 1'b0;
        end else if (acc) begin
            r_s1v <= 1'b1;
        end else if (s1_adv) begin
            r_s1v <= 1'b0;
        end
    end

    // Stage 1 payload and forwarding
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_col    <= r_in_col;
            r_s1_px     <= in_px;
            r_s1_primed <= primed;
            r_s1_border <= border;
            r_s1_last   <= last;
            r_s1_fwd    <= s1_adv && (r_s1_col == r_in_col);
            r_fwd_up    <= s1_mid;
            r_fwd_mid   <= r_s1_px;
        end
    end

    // Window shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else if (s1_adv) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= s1_up;
            r_win[1][2] <= s1_mid;
            r_win[2][2] <= r_s1_px;
        end
    end

    // Stage 2 control: only items that yield a word go on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2v <= 1'b0;
        end else if (s1_adv) begin
            r_s2v <= r_s1_primed;
        end else if (r_s2v && out_free) begin
            r_s2v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s2_border <= r_s1_border;
            r_s2_last   <= r_s1_last;
        end
    end

    // Weighted 3x3 sum per channel, shifted down by 4
    always_comb begin
        logic [CHAN_W+3:0] sum;
        for (int ch = 0; ch < 3; ch++) begin
            sum = {4'b0, r_win[0][0][ch]} + {3'b0, r_win[0][1][ch], 1'b0}
                + {4'b0, r_win[0][2][ch]} + {3'b0, r_win[1][0][ch], 1'b0}
                + {2'b0, r_win[1][1][ch], 2'b0} + {3'b0, r_win[1][2][ch], 1'b0}
                + {4'b0, r_win[2][0][ch]} + {3'b0, r_win[2][1][ch], 1'b0}
                + {4'b0, r_win[2][2][ch]};
            blur_px[ch] = sum[CHAN_W+3:4];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_s2v && out_free) begin
            r_ov <= 1'b1;
        end else if (o_pix.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2v && out_free) begin
            r_o_px   <= r_s2_border ? r_win[1][1] : blur_px;
            r_o_last <= r_s2_last;
        end
    end

    assign o_pix.valid     = r_ov;
    assign o_pix.red_out   = r_o_px[0];
    assign o_pix.green_out = r_o_px[1];
    assign o_pix.blue_out  = r_o_px[2];
    assign o_pix.frame_end = r_o_last;

    // Checks
    a_fwd_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && s1_adv && r_s1_col == r_in_col) |=> r_s1_fwd)
        else $error("same-column write-back not forwarded");

    a_win_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2v && !out_free) |=> ($stable(r_win[1][1]) && $stable(r_win[2][2])))
        else $error("window moved while stage 2 was stalled");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_col <= r_w_last)
        else $error("input column beyond frame width");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1v && r_s2v && r_ov && !o_pix.ready) |-> !i_pix.ready)
        else $error("input taken with full pipeline");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_s2v))
        else $error("output word without stage 2 item");

endmodule
